/* rtl/vkr_pkg.sv */
// Package for the Vigenere key recovery block: sizes, widths, state codes
// and the English letter frequency table.
// Depends on nothing; every other file imports it.
package vkr_pkg;

    localparam int TEXT_DEPTH  = 4096;
    localparam int MAX_KEY     = 20;

    localparam int ADDR_W      = $clog2(TEXT_DEPTH);
    localparam int CNT_W       = $clog2(TEXT_DEPTH + 1);
    localparam int AD_W        = CNT_W + 1;
    localparam int LEN_W       = $clog2(MAX_KEY + 2);
    localparam int MIN_W       = 13;
    localparam int CHAR_W      = 8;
    localparam int LTR_W       = 5;
    localparam int KLEN_W      = 5;
    localparam int NUM_LETTERS = 26;
    localparam int HIDX_W      = 5;
    localparam int SIDX_W      = 6;

    // chi-squared datapath widths
    localparam int FREQ_W = 14;
    localparam int FN_W   = FREQ_W + CNT_W;
    localparam int OB_W   = CNT_W + 17;
    localparam int A_W    = OB_W;
    localparam int SQ_W   = 2 * A_W;
    localparam int NUM_W  = SQ_W + 20;
    localparam int D1_W   = FN_W + 4;
    localparam int DV_W   = D1_W + 10;
    localparam int SC_W   = 48;

    // index of coincidence widths
    localparam int PS_W   = 2 * CNT_W;
    localparam int IC_W   = 25;
    localparam int TOT_W  = IC_W + LEN_W;

    localparam int OB_SCALE = 100000;
    localparam int EPS_NUM  = 625;
    localparam int Q_SHIFT  = 24;
    localparam int CHI_SHIFT = 20;

    localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(10);
    localparam logic [SC_W-1:0]  SCORE_MAX = {SC_W{1'b1}};

    localparam logic [CHAR_W-1:0] CHR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UZ = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LZ = 8'h7A;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLR,
        ST_READ,
        ST_IC_SUM,
        ST_IC_PREP,
        ST_IC_DIV,
        ST_AVG_DIV,
        ST_CHI_A,
        ST_CHI_B,
        ST_CHI_C,
        ST_CHI_DIV
    } state_t;

    // English letter frequencies in thousandths of a percent
    function automatic logic [FREQ_W-1:0] eng_freq(input logic [HIDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            5'd0:    f = FREQ_W'(8167);
            5'd1:    f = FREQ_W'(1492);
            5'd2:    f = FREQ_W'(2782);
            5'd3:    f = FREQ_W'(4253);
            5'd4:    f = FREQ_W'(12702);
            5'd5:    f = FREQ_W'(2228);
            5'd6:    f = FREQ_W'(2015);
            5'd7:    f = FREQ_W'(6094);
            5'd8:    f = FREQ_W'(6966);
            5'd9:    f = FREQ_W'(153);
            5'd10:   f = FREQ_W'(772);
            5'd11:   f = FREQ_W'(4025);
            5'd12:   f = FREQ_W'(2406);
            5'd13:   f = FREQ_W'(6749);
            5'd14:   f = FREQ_W'(7507);
            5'd15:   f = FREQ_W'(1929);
            5'd16:   f = FREQ_W'(95);
            5'd17:   f = FREQ_W'(5987);
            5'd18:   f = FREQ_W'(6327);
            5'd19:   f = FREQ_W'(9056);
            5'd20:   f = FREQ_W'(2758);
            5'd21:   f = FREQ_W'(978);
            5'd22:   f = FREQ_W'(2360);
            5'd23:   f = FREQ_W'(150);
            5'd24:   f = FREQ_W'(1974);
            5'd25:   f = FREQ_W'(74);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/vkr_text_ram.sv */
// Letter store: one write port, one read port, registered read data.
// Depends on vkr_pkg for depth and widths.
module vkr_text_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [vkr_pkg::ADDR_W-1:0] waddr,
    input  logic [vkr_pkg::LTR_W-1:0]  wdata,
    input  logic [vkr_pkg::ADDR_W-1:0] raddr,
    output logic [vkr_pkg::LTR_W-1:0]  rdata
);
    import vkr_pkg::*;

    logic [LTR_W-1:0] mem [0:TEXT_DEPTH-1];
    logic [LTR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vkr_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on vkr_pkg for operand widths.
module vkr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [vkr_pkg::NUM_W-1:0] dividend,
    input  logic [vkr_pkg::DV_W-1:0]  divisor,
    output logic                      done,
    output logic [vkr_pkg::NUM_W-1:0] quotient
);
    import vkr_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  dq_reg, dq_next;
    logic [DV_W-1:0]   rem_reg, rem_next;
    logic [DV_W-1:0]   dvs_reg, dvs_next;
    logic [DV_W:0]     trial;
    logic              ge;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dq_reg[NUM_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            rem_next = ge ? DV_W'(trial - {1'b0, dvs_reg}) : trial[DV_W-1:0];
            dq_next  = {dq_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dq_reg   <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

/* rtl/vigenere_key_recovery.sv */
// Top level of the Vigenere key recovery block: letter loading, column
// histograms, IC key length search and chi-squared shift fitting.
// Depends on vkr_pkg, vkr_text_ram and vkr_div.
//
//  channel   | handshake              | words
//  ----------+------------------------+---------------------------------------
//  input     | start / busy           | char_code, end_of_text
//  result    | result_strobe          | key_letter, key_length, too_short,
//            |                        | last_key_letter
//  config    | cfg_valid / cfg_ready  | cfg_data (min_text_length)
//
//  A byte is taken every cycle while busy is low; letters go straight to the
//  text memory. The end marker raises busy until the last result is on the ports.
//  Analysis is bound by the shared divider: per column it reads the letters
//  and sums the IC terms, plus one division for the IC when the column holds
//  two letters or more, and one division per key length for the average. Per
//  key column the histogram is rebuilt, then 26 x 26 terms are each set up in
//  ST_CHI_A, ST_CHI_B and ST_CHI_C and take one division. Results come out as
//  one-cycle strobes and cannot be held off. Reset empties the store, sets the
//  minimum length to 10 and leaves the block idle.
module vigenere_key_recovery (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [vkr_pkg::CHAR_W-1:0] char_code,
    input  logic                       end_of_text,
    output logic                       result_strobe,
    output logic [vkr_pkg::LTR_W-1:0]  key_letter,
    output logic [vkr_pkg::KLEN_W-1:0] key_length,
    output logic                       too_short,
    output logic                       last_key_letter,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vkr_pkg::MIN_W-1:0]  cfg_data
);
    import vkr_pkg::*;

    state_t            state_reg, state_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  col_reg, col_next;
    logic [LEN_W-1:0]  win_len_reg, win_len_next;
    logic [TOT_W-1:0]  best_avg_reg, best_avg_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              key_phase_reg, key_phase_next;
    logic [AD_W-1:0]   addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [HIDX_W-1:0] ic_i_reg, ic_i_next;
    logic [PS_W-1:0]   prod_reg, prod_next;
    logic              pv_reg, pv_next;
    logic [PS_W-1:0]   ps_reg, ps_next;
    logic [PS_W-1:0]   nn_reg, nn_next;
    logic              go_reg, go_next;
    logic [HIDX_W-1:0] s_reg, s_next;
    logic [HIDX_W-1:0] i_reg, i_next;
    logic [SC_W-1:0]   chi_reg, chi_next;
    logic [SC_W-1:0]   best_reg, best_next;
    logic [HIDX_W-1:0] bc_reg, bc_next;
    logic [FN_W-1:0]   fn_reg, fn_next;
    logic [OB_W-1:0]   ob_reg, ob_next;
    logic [A_W-1:0]    a_reg, a_next;
    logic [D1_W-1:0]   d1_reg, d1_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [DV_W-1:0]   dv_reg, dv_next;

    logic              res_strobe_reg, res_strobe_next;
    logic [LTR_W-1:0]  res_letter_reg, res_letter_next;
    logic [KLEN_W-1:0] res_len_reg, res_len_next;
    logic              res_short_reg, res_short_next;
    logic              res_last_reg, res_last_next;

    logic [CNT_W-1:0]  hist_reg [0:NUM_LETTERS-1];
    logic              hist_clr, hist_inc;
    logic [HIDX_W-1:0] hist_addr;
    logic [CNT_W-1:0]  hist_q;

    logic              accept, is_upper, is_lower, is_letter;
    logic [LTR_W-1:0]  letter;
    logic              ram_we;
    logic [LTR_W-1:0]  ram_rdata;
    logic              rd_issue;

    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_a, div_q;
    logic [DV_W-1:0]   div_b;

    logic [SIDX_W-1:0] idx_sum;
    logic [HIDX_W-1:0] idx;
    logic              ic_done;
    logic [IC_W-1:0]   ic_val;
    logic [TOT_W-1:0]  avg;
    logic [NUM_W:0]    chi_wide;
    logic [SC_W-1:0]   chi_sum;
    logic              win;

    assign accept    = start && (state_reg == ST_IDLE);
    assign is_upper  = (char_code >= CHR_UA) && (char_code <= CHR_UZ);
    assign is_lower  = (char_code >= CHR_LA) && (char_code <= CHR_LZ);
    assign is_letter = is_upper || is_lower;
    assign letter    = is_lower ? LTR_W'(char_code - CHR_LA) : LTR_W'(char_code - CHR_UA);
    assign ram_we    = accept && is_letter && (count_reg < CNT_W'(TEXT_DEPTH));
    assign rd_issue  = addr_reg < AD_W'(count_reg);

    vkr_text_ram u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (letter),
        .raddr (addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    vkr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // shifted histogram index for the chi-squared pass
    assign idx_sum = SIDX_W'(i_reg) + SIDX_W'(s_reg);
    assign idx     = (idx_sum >= SIDX_W'(NUM_LETTERS)) ?
                     HIDX_W'(idx_sum - SIDX_W'(NUM_LETTERS)) : HIDX_W'(idx_sum);

    always_comb
    begin
        case (state_reg)
            ST_READ:   hist_addr = ram_rdata;
            ST_IC_SUM: hist_addr = ic_i_reg;
            default:   hist_addr = idx;
        endcase
    end

    assign hist_q = hist_reg[hist_addr];

    always_comb
    begin
        case (state_reg)
            ST_IC_DIV:
            begin
                div_a = NUM_W'(ps_reg) << Q_SHIFT;
                div_b = DV_W'(nn_reg);
            end
            ST_AVG_DIV:
            begin
                div_a = NUM_W'(total_reg);
                div_b = DV_W'(len_reg);
            end
            default:
            begin
                div_a = NUM_W'(sq_reg) << CHI_SHIFT;
                div_b = dv_reg;
            end
        endcase
    end

    assign chi_wide = (NUM_W + 1)'(chi_reg) + (NUM_W + 1)'(div_q);
    assign chi_sum  = (chi_wide > (NUM_W + 1)'(SCORE_MAX)) ? SCORE_MAX : chi_wide[SC_W-1:0];
    assign win      = (s_reg == '0) || (chi_sum < best_reg);
    assign avg      = div_q[TOT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        min_next        = min_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        col_next        = col_reg;
        win_len_next    = win_len_reg;
        best_avg_next   = best_avg_reg;
        total_next      = total_reg;
        key_phase_next  = key_phase_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        n_next          = n_reg;
        ic_i_next       = ic_i_reg;
        prod_next       = prod_reg;
        pv_next         = pv_reg;
        ps_next         = ps_reg;
        nn_next         = nn_reg;
        go_next         = go_reg;
        s_next          = s_reg;
        i_next          = i_reg;
        chi_next        = chi_reg;
        best_next       = best_reg;
        bc_next         = bc_reg;
        fn_next         = fn_reg;
        ob_next         = ob_reg;
        a_next          = a_reg;
        d1_next         = d1_reg;
        sq_next         = sq_reg;
        dv_next         = dv_reg;
        res_strobe_next = 1'b0;
        res_letter_next = res_letter_reg;
        res_len_next    = res_len_reg;
        res_short_next  = res_short_reg;
        res_last_next   = res_last_reg;
        hist_clr        = 1'b0;
        hist_inc        = 1'b0;
        div_start       = 1'b0;
        ic_done         = 1'b0;
        ic_val          = '0;

        if (cfg_valid)
        begin
            min_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (end_of_text)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (32'(count_reg) < 32'(min_reg))
                begin
                    res_strobe_next = 1'b1;
                    res_letter_next = '0;
                    res_len_next    = '0;
                    res_short_next  = 1'b1;
                    res_last_next   = 1'b1;
                    count_next      = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    len_next       = LEN_W'(1);
                    col_next       = '0;
                    total_next     = '0;
                    best_avg_next  = '0;
                    win_len_next   = LEN_W'(1);
                    key_phase_next = 1'b0;
                    state_next     = ST_CLR;
                end
            end

            ST_CLR:
            begin
                hist_clr   = 1'b1;
                addr_next  = AD_W'(col_reg);
                n_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_READ;
            end

            ST_READ:
            begin
                // stride through one column; count each letter as its data returns
                if (rd_issue)
                begin
                    addr_next = addr_reg + AD_W'(len_reg);
                end
                pend_next = rd_issue;
                if (pend_reg)
                begin
                    hist_inc = 1'b1;
                    n_next   = n_reg + CNT_W'(1);
                end
                if (!rd_issue && !pend_reg)
                begin
                    if (key_phase_reg)
                    begin
                        s_next     = '0;
                        i_next     = '0;
                        chi_next   = '0;
                        best_next  = '0;
                        bc_next    = '0;
                        state_next = ST_CHI_A;
                    end
                    else
                    begin
                        ic_i_next  = '0;
                        pv_next    = 1'b0;
                        ps_next    = '0;
                        state_next = ST_IC_SUM;
                    end
                end
            end

            ST_IC_SUM:
            begin
                if (ic_i_reg < HIDX_W'(NUM_LETTERS))
                begin
                    prod_next = PS_W'(hist_q) *
                                PS_W'((hist_q == '0) ? hist_q : hist_q - CNT_W'(1));
                    pv_next   = 1'b1;
                    ic_i_next = ic_i_reg + HIDX_W'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    ps_next = ps_reg + prod_reg;
                end
                if ((ic_i_reg == HIDX_W'(NUM_LETTERS)) && !pv_reg)
                begin
                    state_next = ST_IC_PREP;
                end
            end

            ST_IC_PREP:
            begin
                nn_next = PS_W'(n_reg) * PS_W'(n_reg - CNT_W'(1));
                if (n_reg < CNT_W'(2))
                begin
                    ic_done = 1'b1;
                end
                else
                begin
                    go_next    = 1'b1;
                    state_next = ST_IC_DIV;
                end
            end

            ST_IC_DIV:
            begin
                if (go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b0;
                end
                if (div_done)
                begin
                    ic_done = 1'b1;
                    ic_val  = div_q[IC_W-1:0];
                end
            end

            ST_AVG_DIV:
            begin
                if (go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b0;
                end
                if (div_done)
                begin
                    col_next   = '0;
                    total_next = '0;
                    state_next = ST_CLR;
                    if (avg > best_avg_reg)
                    begin
                        best_avg_next = avg;
                        win_len_next  = len_reg;
                    end
                    if (len_reg == LEN_W'(MAX_KEY))
                    begin
                        // length settled: fit shifts on its columns
                        key_phase_next = 1'b1;
                        len_next       = (avg > best_avg_reg) ? len_reg : win_len_reg;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end

            ST_CHI_A:
            begin
                fn_next    = FN_W'(eng_freq(i_reg)) * FN_W'(n_reg);
                ob_next    = OB_W'(hist_q) * OB_W'(OB_SCALE);
                state_next = ST_CHI_B;
            end

            ST_CHI_B:
            begin
                a_next     = (ob_reg > OB_W'(fn_reg)) ? A_W'(ob_reg - OB_W'(fn_reg))
                                                      : A_W'(OB_W'(fn_reg) - ob_reg);
                d1_next    = (D1_W'(fn_reg) << 3) + (D1_W'(fn_reg) << 1) + D1_W'(1);
                state_next = ST_CHI_C;
            end

            ST_CHI_C:
            begin
                sq_next    = SQ_W'(a_reg) * SQ_W'(a_reg);
                dv_next    = DV_W'(d1_reg) * DV_W'(EPS_NUM);
                go_next    = 1'b1;
                state_next = ST_CHI_DIV;
            end

            ST_CHI_DIV:
            begin
                if (go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b0;
                end
                if (div_done)
                begin
                    state_next = ST_CHI_A;
                    if (i_reg == HIDX_W'(NUM_LETTERS - 1))
                    begin
                        if (win)
                        begin
                            best_next = chi_sum;
                            bc_next   = s_reg;
                        end
                        if (s_reg == HIDX_W'(NUM_LETTERS - 1))
                        begin
                            res_strobe_next = 1'b1;
                            res_letter_next = win ? s_reg : bc_reg;
                            res_len_next    = KLEN_W'(len_reg);
                            res_short_next  = 1'b0;
                            res_last_next   = (col_reg + LEN_W'(1)) == len_reg;
                            if ((col_reg + LEN_W'(1)) == len_reg)
                            begin
                                count_next = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                col_next   = col_reg + LEN_W'(1);
                                state_next = ST_CLR;
                            end
                        end
                        else
                        begin
                            s_next   = s_reg + HIDX_W'(1);
                            i_next   = '0;
                            chi_next = '0;
                        end
                    end
                    else
                    begin
                        i_next   = i_reg + HIDX_W'(1);
                        chi_next = chi_sum;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one column's IC is in: accumulate, then next column or average
        if (ic_done)
        begin
            total_next = total_reg + TOT_W'(ic_val);
            if ((col_reg + LEN_W'(1)) == len_reg)
            begin
                go_next    = 1'b1;
                state_next = ST_AVG_DIV;
            end
            else
            begin
                col_next   = col_reg + LEN_W'(1);
                state_next = ST_CLR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_clr)
        begin
            for (int k = 0; k < NUM_LETTERS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (hist_inc)
        begin
            hist_reg[hist_addr] <= hist_q + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_reg        <= MIN_RESET;
            count_reg      <= '0;
            len_reg        <= '0;
            col_reg        <= '0;
            win_len_reg    <= '0;
            best_avg_reg   <= '0;
            total_reg      <= '0;
            key_phase_reg  <= 1'b0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            n_reg          <= '0;
            ic_i_reg       <= '0;
            prod_reg       <= '0;
            pv_reg         <= 1'b0;
            ps_reg         <= '0;
            nn_reg         <= '0;
            go_reg         <= 1'b0;
            s_reg          <= '0;
            i_reg          <= '0;
            chi_reg        <= '0;
            best_reg       <= '0;
            bc_reg         <= '0;
            fn_reg         <= '0;
            ob_reg         <= '0;
            a_reg          <= '0;
            d1_reg         <= '0;
            sq_reg         <= '0;
            dv_reg         <= '0;
            res_strobe_reg <= 1'b0;
            res_letter_reg <= '0;
            res_len_reg    <= '0;
            res_short_reg  <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_reg        <= min_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            col_reg        <= col_next;
            win_len_reg    <= win_len_next;
            best_avg_reg   <= best_avg_next;
            total_reg      <= total_next;
            key_phase_reg  <= key_phase_next;
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            n_reg          <= n_next;
            ic_i_reg       <= ic_i_next;
            prod_reg       <= prod_next;
            pv_reg         <= pv_next;
            ps_reg         <= ps_next;
            nn_reg         <= nn_next;
            go_reg         <= go_next;
            s_reg          <= s_next;
            i_reg          <= i_next;
            chi_reg        <= chi_next;
            best_reg       <= best_next;
            bc_reg         <= bc_next;
            fn_reg         <= fn_next;
            ob_reg         <= ob_next;
            a_reg          <= a_next;
            d1_reg         <= d1_next;
            sq_reg         <= sq_next;
            dv_reg         <= dv_next;
            res_strobe_reg <= res_strobe_next;
            res_letter_reg <= res_letter_next;
            res_len_reg    <= res_len_next;
            res_short_reg  <= res_short_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign result_strobe   = res_strobe_reg;
    assign key_letter      = res_letter_reg;
    assign key_length      = res_len_reg;
    assign too_short       = res_short_reg;
    assign last_key_letter = res_last_reg;

endmodule
